@@ sv/gsa_pkg.sv @@
`default_nettype none
package gsa_pkg;
    localparam int MaxStates    = 4096;
    localparam int AlphabetSize = 26;
    localparam int StW          = $clog2(MaxStates);
    localparam int SymW         = 5;
    localparam int CntW         = 24;
    localparam int TransDepth   = MaxStates * AlphabetSize;
    localparam int TransAw      = $clog2(TransDepth);

    localparam logic [1:0] StatusOk     = 2'd0;
    localparam logic [1:0] StatusFull   = 2'd1;
    localparam logic [1:0] StatusUnallo = 2'd2;

    localparam logic ActClear  = 1'b0;
    localparam logic ActExtend = 1'b1;

    typedef struct packed {
        logic             action;
        logic [SymW-1:0]  symbol;
        logic [StW-1:0]   prev_state;
    } t_in;

    typedef struct packed {
        logic [StW-1:0]   new_state;
        logic [CntW-1:0]  distinct_count;
        logic [1:0]       status;
    } t_out;

    // Flat address of (state, symbol) in the transition store.
    function automatic logic [TransAw-1:0] trans_addr(input logic [StW-1:0] s,
                                                      input logic [SymW-1:0] c);
        logic [TransAw-1:0] base;
        base = TransAw'(s) * TransAw'(AlphabetSize);
        return base + TransAw'(c);
    endfunction
endpackage
`default_nettype wire

@@ sv/generalized_suffix_automaton_builder.sv @@
// Steps per request: a clear sweeps the root row; a new state clears its row and walks suffix links,
//   comparing lengths when the walk ends on a transition; a clone copies its row entry by entry
//   and redirects transitions along the link chain.
// Throughput: one request at a time; o_ready is low until the last result has been taken.
//   Each row clear, row copy and link step goes through the single-port transition memory.
// Reset: synchronous active-low i_rst_n; ready stays low for the root sweep, count zero.
`default_nettype none
module generalized_suffix_automaton_builder import gsa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);
    // Transition store: one entry per (state, symbol), registered read.
    logic [StW-1:0] trans_mem [TransDepth];
    logic [StW-1:0] len_mem   [MaxStates];
    logic [StW-1:0] link_mem  [MaxStates];

    // Memory ports, driven by the sequencer below.
    logic               t_we, l_we, k_we;
    logic [TransAw-1:0] t_addr;
    logic [StW-1:0]     t_wd, t_rd;
    logic [StW-1:0]     l_waddr, l_wd, l_raddr, l_rd;
    logic [StW-1:0]     k_waddr, k_wd, k_raddr, k_rd;

    always_ff @(posedge i_clk) begin
        if (t_we) trans_mem[t_addr] <= t_wd;
        t_rd <= trans_mem[t_addr];
        if (l_we) len_mem[l_waddr] <= l_wd;
        l_rd <= len_mem[l_raddr];
        if (k_we) link_mem[k_waddr] <= k_wd;
        k_rd <= link_mem[k_raddr];
    end

    typedef enum logic [4:0] {
        S_IDLE, S_CLR_ROOT, S_RD_Q, S_GOT_Q, S_CMP_Q, S_SETLEN_P, S_ZERO_P,
        S_WALK_RD, S_WALK_CHK, S_WALK_LINK, S_WALK_LWAIT, S_FIN_Q, S_FIN_CMP,
        S_CL_INIT, S_CL_LINK, S_CL_COPY_RD, S_CL_COPY_WR, S_CL_RED_RD,
        S_CL_RED_CHK, S_CL_RED_LNK, S_CL_RED_LW, S_CL_DONE,
        S_CNT_RD, S_CNT_ADD, S_OUT
    } t_state;

    t_state           r_st;
    t_in              r_req;
    logic [StW-1:0]   r_used, r_s, r_q, r_p, r_cl, r_link_p, r_len_p;
    logic [StW-1:0]   r_ls;
    logic [SymW-1:0]  r_idx;
    logic [CntW-1:0]  r_total;
    logic             r_split_final;   // clone made in the final step of a new-state extend
    logic             r_clr_rep;       // a clear request awaits its result after the sweep
    logic             r_vld;
    t_out             r_out;

    logic [SymW-1:0] sym_sat;
    assign sym_sat = (i_data.symbol >= SymW'(AlphabetSize)) ?
                     SymW'(AlphabetSize - 1) : i_data.symbol;

    logic [CntW:0] sum;
    assign sum = {1'b0, r_total} + (CntW+1)'(r_len_p - l_rd);

    assign o_ready = (r_st == S_IDLE) && !r_vld;
    assign o_valid = r_vld;
    assign o_data  = r_out;

    // Memory port selection per state.
    always_comb begin
        t_we = 1'b0; t_addr = trans_addr(r_s, r_req.symbol); t_wd = '0;
        l_we = 1'b0; l_waddr = r_p; l_wd = '0; l_raddr = r_q;
        k_we = 1'b0; k_waddr = r_p; k_wd = '0; k_raddr = r_s;
        unique case (r_st)
            S_CLR_ROOT: begin
                t_we = 1'b1; t_addr = trans_addr('0, r_idx);
                l_we = 1'b1; l_waddr = '0;
            end
            S_RD_Q:      begin l_raddr = r_s; end
            S_GOT_Q:     begin l_raddr = t_rd; end
            S_SETLEN_P:  begin l_we = 1'b1; l_waddr = r_p; l_wd = r_ls + 1'b1; end
            S_ZERO_P: begin
                t_we = 1'b1; t_addr = trans_addr(r_p, r_idx);
            end
            S_WALK_RD:   begin k_raddr = r_s; end
            S_WALK_CHK: begin
                if (t_rd == '0) begin
                    t_we = 1'b1; t_wd = r_p;
                end
            end
            S_FIN_Q:     begin l_raddr = r_s; end
            S_FIN_CMP:   begin l_raddr = r_q; end
            S_CL_INIT: begin
                l_we = 1'b1; l_waddr = r_cl; l_wd = r_ls + 1'b1; k_raddr = r_q;
            end
            S_CL_LINK: begin
                k_we = 1'b1; k_waddr = r_cl; k_wd = k_rd;
                t_addr = trans_addr(r_q, r_idx);
            end
            S_CL_COPY_RD: begin t_addr = trans_addr(r_q, r_idx); end
            // r_idx is already one past the entry that was read.
            S_CL_COPY_WR: begin
                t_we = 1'b1; t_addr = trans_addr(r_cl, r_idx - 1'b1); t_wd = t_rd;
            end
            S_CL_RED_RD: begin k_raddr = r_s; end
            S_CL_RED_CHK: begin
                k_raddr = r_s;
                if (t_rd == r_q) begin
                    t_we = 1'b1; t_wd = r_cl;
                end
            end
            S_CL_DONE:   begin k_we = 1'b1; k_waddr = r_q; k_wd = r_cl; end
            S_CNT_RD: begin
                k_we = 1'b1; k_waddr = r_p; k_wd = r_link_p; l_raddr = r_link_p;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR_ROOT; r_idx <= '0; r_used <= '0; r_total <= '0;
            r_vld <= 1'b0; r_split_final <= 1'b0; r_clr_rep <= 1'b0;
        end else begin
            if (r_vld && i_ready) r_vld <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req <= '{action: i_data.action, symbol: sym_sat,
                                   prev_state: i_data.prev_state};
                        r_s <= i_data.prev_state;
                        r_idx <= '0;
                        if (i_data.action == ActClear) begin
                            r_used <= '0; r_total <= '0;
                            r_out <= '{new_state: '0, distinct_count: '0, status: StatusOk};
                            r_st <= S_CLR_ROOT;
                            r_clr_rep <= 1'b1;
                        end else if (i_data.prev_state > r_used) begin
                            r_out <= '{new_state: '0, distinct_count: r_total,
                                       status: StatusUnallo};
                            r_vld <= 1'b1;
                        end else if ({1'b0, r_used} + (StW+1)'(2) >
                                     (StW+1)'(MaxStates - 1)) begin
                            r_out <= '{new_state: '0, distinct_count: r_total,
                                       status: StatusFull};
                            r_vld <= 1'b1;
                        end else begin
                            r_st <= S_RD_Q;
                        end
                    end
                end
                // Sweep the root row to zero, root length zero.
                S_CLR_ROOT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SymW'(AlphabetSize - 1)) begin
                        r_st <= S_IDLE;
                        // After reset no request is outstanding; a clear reports.
                        if (r_clr_rep) r_vld <= 1'b1;
                        r_clr_rep <= 1'b0;
                    end
                end
                S_RD_Q: r_st <= S_GOT_Q;          // t_rd <= trans[last][c], l_rd <= len[last]
                S_GOT_Q: begin
                    r_q <= t_rd; r_ls <= l_rd;
                    if (t_rd != '0) r_st <= S_CMP_Q;
                    else begin
                        r_p <= r_used + 1'b1; r_used <= r_used + 1'b1;
                        r_st <= S_SETLEN_P;
                    end
                end
                S_CMP_Q: begin                      // l_rd = len[q]
                    if (l_rd == r_ls + 1'b1) begin
                        r_out <= '{new_state: r_q, distinct_count: r_total, status: StatusOk};
                        r_vld <= 1'b1; r_st <= S_IDLE;
                    end else begin
                        r_split_final <= 1'b0;
                        r_cl <= r_used + 1'b1; r_used <= r_used + 1'b1;
                        r_st <= S_CL_INIT;
                    end
                end
                S_SETLEN_P: begin
                    r_len_p <= r_ls + 1'b1; r_idx <= '0; r_st <= S_ZERO_P;
                end
                S_ZERO_P: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SymW'(AlphabetSize - 1)) r_st <= S_WALK_RD;
                end
                S_WALK_RD: r_st <= S_WALK_CHK;    // t_rd = trans[s][c], k_rd = link[s]
                S_WALK_CHK: begin
                    if (t_rd != '0) begin
                        r_q <= t_rd; r_st <= S_FIN_Q;
                    end else if (r_s == '0) begin
                        r_link_p <= '0; r_st <= S_CNT_RD;
                    end else begin
                        r_s <= k_rd; r_st <= S_WALK_RD;
                    end
                end
                S_FIN_Q: r_st <= S_FIN_CMP;       // l_rd <= len[s]
                S_FIN_CMP: begin
                    r_ls <= l_rd;
                    r_st <= S_WALK_LINK;
                end
                S_WALK_LINK: r_st <= S_WALK_LWAIT; // l_rd <= len[q]
                S_WALK_LWAIT: begin
                    if (l_rd == r_ls + 1'b1) begin
                        r_link_p <= r_q; r_st <= S_CNT_RD;
                    end else begin
                        r_split_final <= 1'b1;
                        r_cl <= r_used + 1'b1; r_used <= r_used + 1'b1;
                        r_st <= S_CL_INIT;
                    end
                end
                S_CL_INIT: begin r_idx <= '0; r_st <= S_CL_LINK; end
                S_CL_LINK: begin r_idx <= r_idx + 1'b1; r_st <= S_CL_COPY_WR; end
                S_CL_COPY_RD: begin r_idx <= r_idx + 1'b1; r_st <= S_CL_COPY_WR; end
                S_CL_COPY_WR: begin
                    if (r_idx == SymW'(AlphabetSize)) r_st <= S_CL_RED_RD;
                    else r_st <= S_CL_COPY_RD;
                end
                S_CL_RED_RD: r_st <= S_CL_RED_CHK;
                S_CL_RED_CHK: begin
                    if (t_rd != r_q || r_s == '0) r_st <= S_CL_DONE;
                    else begin r_s <= k_rd; r_st <= S_CL_RED_RD; end
                end
                S_CL_DONE: begin
                    if (r_split_final) begin
                        r_link_p <= r_cl; r_st <= S_CNT_RD;
                    end else begin
                        r_out <= '{new_state: r_cl, distinct_count: r_total, status: StatusOk};
                        r_vld <= 1'b1; r_st <= S_IDLE;
                    end
                end
                S_CNT_RD: r_st <= S_CNT_ADD;       // l_rd <= len[link[p]]
                S_CNT_ADD: begin
                    r_total <= sum[CntW] ? '1 : sum[CntW-1:0];
                    r_out <= '{new_state: r_p, distinct_count: sum[CntW] ? '1 : sum[CntW-1:0],
                               status: StatusOk};
                    r_vld <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> r_st == S_IDLE) else $error("result shown mid-request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE && i_valid && o_ready && i_data.action == ActExtend
         && i_data.prev_state > r_used) |=> r_vld && r_out.status == StatusUnallo)
        else $error("unallocated prev not rejected");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.action == ActExtend && i_data.prev_state <= r_used
         && r_used > StW'(MaxStates - 3)) |=> r_vld && r_out.status == StatusFull)
        else $error("full store not rejected");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_ready) |=> r_vld && $stable(r_out)) else $error("result lost");
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none

import gsa_pkg::*;

// Checks each result against the expected result, oldest first.
// Holds its own copy of the automaton and updates it as each request is accepted.
class automaton_scoreboard;
    logic [StW-1:0]  next_state [MaxStates*AlphabetSize];
    logic [StW-1:0]  path_len   [MaxStates];
    logic [StW-1:0]  link_of    [MaxStates];
    int unsigned     used;
    int unsigned     total;
    t_out            expected_q [$];
    int              mismatches;
    int              checked;
    int              full_seen;
    int              unallo_seen;
    int              clones;

    function void wipe();
        used  = 0;
        total = 0;
        path_len[0] = '0;
        link_of[0]  = '0;
        for (int c = 0; c < AlphabetSize; c++) next_state[c] = '0;
    endfunction

    function new();
        mismatches = 0;
        checked = 0;
        full_seen = 0;
        unallo_seen = 0;
        clones = 0;
        wipe();
    endfunction

    // Split q (target of s on c) into a clone one longer than s.
    function int unsigned split_state(int unsigned s, int unsigned c, int unsigned q);
        int unsigned cl;
        cl = ++used;
        clones++;
        path_len[cl] = path_len[s] + 1;
        link_of[cl]  = link_of[q];
        for (int k = 0; k < AlphabetSize; k++)
            next_state[cl*AlphabetSize+k] = next_state[q*AlphabetSize+k];
        forever begin
            if (next_state[s*AlphabetSize+c] != q) break;
            next_state[s*AlphabetSize+c] = cl;
            if (s == 0) break;
            s = link_of[s];
        end
        link_of[q] = cl;
        return cl;
    endfunction

    function int unsigned append_symbol(int unsigned c, int unsigned last);
        int unsigned q, p, s, sum;
        bit walked_off;
        walked_off = 0;
        q = next_state[last*AlphabetSize+c];
        if (q != 0) begin
            if (path_len[q] == path_len[last] + 1) return q;
            return split_state(last, c, q);
        end
        p = ++used;
        path_len[p] = path_len[last] + 1;
        for (int k = 0; k < AlphabetSize; k++) next_state[p*AlphabetSize+k] = '0;
        s = last;
        forever begin
            if (next_state[s*AlphabetSize+c] != 0) break;
            next_state[s*AlphabetSize+c] = p;
            if (s == 0) begin
                walked_off = 1;
                break;
            end
            s = link_of[s];
        end
        if (walked_off) begin
            link_of[p] = '0;
        end else begin
            q = next_state[s*AlphabetSize+c];
            if (path_len[q] == path_len[s] + 1) link_of[p] = q;
            else link_of[p] = split_state(s, c, q);
        end
        sum = total + (path_len[p] - path_len[link_of[p]]);
        total = (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum;
        return p;
    endfunction

    // Advance the copy for one accepted request; return the predicted state.
    function logic [StW-1:0] note_request(t_in req);
        t_out        exp;
        int unsigned sym;
        exp = '0;
        if (req.action == ActClear) begin
            wipe();
        end else if (req.prev_state > used) begin
            exp.status = StatusUnallo;
            unallo_seen++;
        end else if (used + 2 > MaxStates - 1) begin
            exp.status = StatusFull;
            full_seen++;
        end else begin
            sym = (req.symbol >= AlphabetSize) ? AlphabetSize - 1 : req.symbol;
            exp.new_state = StW'(append_symbol(sym, req.prev_state));
        end
        exp.distinct_count = CntW'(total);
        expected_q.push_back(exp);
        return exp.new_state;
    endfunction

    function void check_result(t_out got);
        t_out exp;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("result with nothing expected: %p", got);
            return;
        end
        exp = expected_q.pop_front();
        checked++;
        if (got.new_state !== exp.new_state || got.distinct_count !== exp.distinct_count
                || got.status !== exp.status) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch #%0d: state %0d/%0d count %0d/%0d status %0d/%0d (exp/got)",
                         checked, exp.new_state, got.new_state, exp.distinct_count,
                         got.distinct_count, exp.status, got.status);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data = '0;
    logic o_ready, o_valid;
    t_out o_data;

    automaton_scoreboard sb = new();

    // Burst mode turns off sender gaps; hold_off asks the receiver for a long stall.
    bit   burst_mode = 0;
    bit   hold_off = 0;
    int   sent = 0;
    logic [StW-1:0] tail_state;

    always #4 i_clk = ~i_clk;

    generalized_suffix_automaton_builder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode) return 0;
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    // Offer one request, hold it until accepted, then update the prediction.
    task send_request(input logic act, input logic [SymW-1:0] sym,
                      input logic [StW-1:0] prev);
        int   gap;
        t_in  req;
        gap = pick_gap();
        req.action = act;
        req.symbol = sym;
        req.prev_state = prev;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (!o_ready);
        tail_state = sb.note_request(req);
        sent++;
    endtask

    // Append one symbol to the string that currently ends at tail_state.
    task grow(input logic [SymW-1:0] sym);
        send_request(ActExtend, sym, tail_state);
    endtask

    // Receiver: random ready, occasional long hold-off counted here.
    initial begin
        int stall;
        bit steady;
        steady = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) sb.check_result(o_data);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end else begin
                if ($urandom_range(0, 199) == 0) steady = ~steady;
                stall = $urandom_range(0, 99);
                if (steady) i_ready <= 1'b1;
                else if (stall < 60) i_ready <= 1'b1;
                else if (stall < 97) i_ready <= 1'b0;
                else begin
                    i_ready <= 1'b0;
                    repeat ($urandom_range(20, 60)) @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus
    initial begin
        int           str_left, alpha;
        int unsigned  r;
        logic [SymW-1:0] sym;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: clear, symbol extremes incl. saturation, unallocated prev,
        // repeated string for existing transitions, clone-forcing strings.
        send_request(ActClear, '0, '0);
        send_request(ActExtend, 5'd0, 12'd0);
        send_request(ActExtend, 5'd25, 12'd0);
        send_request(ActExtend, 5'd31, 12'd0);
        send_request(ActExtend, 5'd3, 12'hFFF);
        send_request(ActExtend, 5'd3, 12'd5);
        tail_state = '0;
        for (int i = 0; i < 5; i++) grow(5'(i % 2));
        tail_state = '0;
        grow(5'd1); grow(5'd1); grow(5'd0);
        tail_state = '0;
        grow(5'd0); grow(5'd0); grow(5'd1);
        tail_state = '0;
        grow(5'd2); grow(5'd0); grow(5'd1);
        send_request(ActClear, 5'd31, 12'hFFF);
        send_request(ActExtend, 5'd30, 12'd0);

        // Random: mostly well-formed strings over small alphabets, some noise.
        str_left = 0;
        alpha = 2;
        for (int n = 0; n < 1100; n++) begin
            if (n % 150 == 0) burst_mode = ~burst_mode;
            if (n == 300) hold_off = 1;
            if (n == 600) begin
                i_valid <= 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            if (r < 2) begin
                send_request(ActClear, 5'($urandom), 12'($urandom));
                str_left = 0;
            end else if (r < 6) begin
                send_request(ActExtend, 5'($urandom), 12'($urandom_range(0, 4095)));
            end else if (r < 10) begin
                send_request(ActExtend, 5'($urandom),
                             12'($urandom_range(0, sb.used)));
            end else begin
                if (str_left == 0) begin
                    str_left = $urandom_range(1, 14);
                    alpha = ($urandom_range(0, 3) == 0) ? 26 : $urandom_range(2, 4);
                    tail_state = '0;
                end
                sym = ($urandom_range(0, 49) == 0) ? 5'($urandom_range(26, 31))
                                                    : 5'($urandom_range(0, alpha - 1));
                grow(sym);
                str_left--;
            end
        end

        // Close with a clear and a fresh start.
        send_request(ActClear, '0, '0);
        send_request(ActExtend, 5'd4, 12'd0);
        i_valid <= 1'b0;

        // Drain, then let the block settle.
        for (int w = 0; w < 200000 && sb.pending() != 0; w++) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d requests, checked %0d results, %0d mismatches",
                 sent, sb.checked, sb.mismatches);
        $display("clones %0d, full rejects %0d, unallocated rejects %0d",
                 sb.clones, sb.full_seen, sb.unallo_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
sv/gsa_pkg.sv
sv/generalized_suffix_automaton_builder.sv
verif/tb_top.sv
